// ===== rtl/rfpg_pkg.sv =====
// Shared constants, types and elaboration-time helpers for the radial
// falloff pixel generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rfpg_pkg;

    // Geometry and fixed point
    localparam int MAX_DIM    = 4096;
    localparam int FB         = 16;                 // fraction bits
    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int DEN_W      = $clog2(MAX_DIM);    // dim - 1
    localparam int NUM_W      = COORD_W + 1;        // |2*p - d|
    localparam int MAG_W      = FB + 1;             // 0 .. 1.0 inclusive
    localparam int LOGM_W     = $clog2(FB);
    localparam int NL_W       = FB + LOGM_W + 1;
    localparam int EXP_Q      = 30;                 // exp2 accumulator fraction bits
    localparam int EXP_W      = EXP_Q + 1;

    // Register widths
    localparam int POW_W      = 16;
    localparam int PEAK_W     = 17;
    localparam int PSTR_W     = 5;
    localparam int RSTR_W     = 17;
    localparam int CHAN_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Result widths
    localparam int ADDR_W     = 28;
    localparam int VAL_W      = 8;

    // Exponent: Q8.8 power, halved
    localparam int POW_SHIFT  = 9;
    localparam int E_W        = POW_W + NL_W - POW_SHIFT;

    // Output scaling: * 255996 >> (FB + 16), then / 1000 by reciprocal
    localparam int SCALE_W     = 18;
    localparam int SCALE_SHIFT = FB + 16;
    localparam int P1_W        = 2 * MAG_W;
    localparam int P2_W        = 18;
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 28;
    localparam logic [SCALE_W-1:0] VALUE_SCALE = SCALE_W'(255996);
    localparam logic [RECIP_W-1:0] RECIP_1000  = RECIP_W'(268436);
    localparam int VAL_MAX = 255;

    localparam logic [MAG_W-1:0] ONE = MAG_W'(1) << FB;

    // Register reset values
    localparam logic [DIM_W-1:0]  RST_WIDTH  = DIM_W'(256);
    localparam logic [DIM_W-1:0]  RST_HEIGHT = DIM_W'(256);
    localparam logic [POW_W-1:0]  RST_POWER  = POW_W'(256);
    localparam logic [PEAK_W-1:0] RST_PEAK   = PEAK_W'(65536);
    localparam logic [PSTR_W-1:0] RST_PSTR   = PSTR_W'(4);
    localparam logic [RSTR_W-1:0] RST_RSTR   = RSTR_W'(1024);
    localparam logic [CHAN_W-1:0] RST_CHAN   = CHAN_W'(0);

    // Unit latencies and stage positions in the valid line
    localparam int DIV_LAT    = FB;
    localparam int LOG_LAT    = FB + 1;
    localparam int EXP_LAT    = FB;
    localparam int ST_IN      = 0;
    localparam int ST_MAG     = ST_IN + DIV_LAT;
    localparam int ST_SQ      = ST_MAG + 1;
    localparam int ST_BASE    = ST_SQ + 1;
    localparam int ST_LOG     = ST_BASE + LOG_LAT;
    localparam int ST_EXPO    = ST_LOG + 1;
    localparam int ST_EXP     = ST_EXPO + EXP_LAT;
    localparam int ST_ALPHA   = ST_EXP + 1;
    localparam int ST_PROD    = ST_ALPHA + 1;
    localparam int ST_SCALE   = ST_PROD + 1;
    localparam int ST_VAL     = ST_SCALE + 1;
    localparam int PIPE_DEPTH = ST_VAL + 1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_POWER  = 3'd2,
        CFG_PEAK   = 3'd3,
        CFG_PSTR   = 3'd4,
        CFG_RSTR   = 3'd5,
        CFG_CHAN   = 3'd6
    } cfg_index_t;

    // Special-case flags riding along the log/exp units
    typedef struct packed {
        logic spec;      // result fixed, skip pow
        logic spec_one;  // fixed result is 1.0 (else 0)
    } rfpg_flag_t;

    // Bitwise integer square root, elaboration use only
    function automatic logic [63:0] isqrt64(input logic [63:0] value);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = value;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // k-th exp2 constant 2^(-2^-k) in Q30, built by repeated square roots
    function automatic logic [EXP_W-1:0] exp_const(input int k);
        logic [63:0] c;
        c = isqrt64(64'd1 << (2 * EXP_Q - 1));
        for (int j = 2; j <= FB; j++)
        begin
            if (j <= k)
                c = isqrt64(c << EXP_Q);
        end
        return EXP_W'(c);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rfpg_if.sv =====
// Valid/ready channel interfaces for pixel requests and results.
// Depends on rfpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rfpg_pixel_if import rfpg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface rfpg_result_if import rfpg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] byte_address;
    logic [VAL_W-1:0]  pixel_value;

    modport source (output valid, output byte_address, output pixel_value, input ready);
    modport sink   (input valid, input byte_address, input pixel_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/rfpg_axis_div.sv =====
// Pipelined restoring divider for one axis: (num << FB) / den, one quotient
// bit per stage, saturated to 1.0. Depends on rfpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfpg_axis_div import rfpg_pkg::*; (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [DEN_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    input  wire logic             sat,
    output logic      [MAG_W-1:0] mag
);

    logic [DEN_W-1:0] rem_reg [DIV_LAT];
    logic [DEN_W-1:0] den_reg [DIV_LAT];
    logic [FB-1:0]    q_reg   [DIV_LAT];
    logic             sat_reg [DIV_LAT];

    for (genvar k = 0; k < DIV_LAT; k++)
    begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [FB-1:0]    q_in;
        logic             sat_in;
        logic [DEN_W:0]   trial;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
            assign sat_in = sat;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign sat_in = sat_reg[k-1];
        end

        assign trial = {rem_in, 1'b0};

        // one restoring step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k] <= den_in;
                sat_reg[k] <= sat_in;
                if (trial >= {1'b0, den_in})
                begin
                    rem_reg[k] <= DEN_W'(trial - {1'b0, den_in});
                    q_reg[k]   <= {q_in[FB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= DEN_W'(trial);
                    q_reg[k]   <= {q_in[FB-2:0], 1'b0};
                end
            end
        end
    end

    assign mag = sat_reg[DIV_LAT-1] ? ONE : {1'b0, q_reg[DIV_LAT-1]};

endmodule

`default_nettype wire

// ===== rtl/rfpg_log2.sv =====
// Pipelined fixed-point log2: normalize, then one squaring step per stage
// giving one fraction bit each. Depends on rfpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfpg_log2 import rfpg_pkg::*; (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [FB-1:0]     base,
    output logic      [FB-1:0]     frac,
    output logic      [LOGM_W-1:0] msb
);

    logic [MAG_W-1:0]  norm_reg [LOG_LAT];
    logic [FB-1:0]     frac_reg [LOG_LAT];
    logic [LOGM_W-1:0] m_reg    [LOG_LAT];
    logic [LOGM_W-1:0] m_next;

    // top set bit
    always_comb
    begin
        m_next = '0;
        for (int b = 0; b < FB; b++)
        begin
            if (base[b])
                m_next = LOGM_W'(b);
        end
    end

    // normalize to [1.0, 2.0); shift of FB - m needs one extra bit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]    <= m_next;
            frac_reg[0] <= '0;
            norm_reg[0] <= MAG_W'(base) << ((LOGM_W + 1)'(FB) - (LOGM_W + 1)'(m_next));
        end
    end

    for (genvar i = 1; i < LOG_LAT; i++)
    begin : g_sq
        localparam logic [FB-1:0] BIT_MASK = FB'(1) << (FB - i);
        logic [2*MAG_W-1:0] prod;
        logic [MAG_W:0]     sq;

        assign prod = norm_reg[i-1] * norm_reg[i-1];
        assign sq   = prod[FB+MAG_W:FB];

        // square; halve and emit a one when it reaches 2.0
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[i] <= m_reg[i-1];
                if (sq[MAG_W])
                begin
                    norm_reg[i] <= sq[MAG_W:1];
                    frac_reg[i] <= frac_reg[i-1] | BIT_MASK;
                end
                else
                begin
                    norm_reg[i] <= sq[MAG_W-1:0];
                    frac_reg[i] <= frac_reg[i-1];
                end
            end
        end
    end

    assign frac = frac_reg[LOG_LAT-1];
    assign msb  = m_reg[LOG_LAT-1];

endmodule

`default_nettype wire

// ===== rtl/rfpg_exp2.sv =====
// Pipelined exp2 of a negative fraction in Q30: one constant multiply per
// stage over the fraction bits, MSB first. Depends on rfpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfpg_exp2 import rfpg_pkg::*; (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [FB-1:0]    frac,
    output logic      [EXP_W-1:0] acc
);

    localparam logic [EXP_W-1:0] EXP_ONE = EXP_W'(1) << EXP_Q;

    logic [EXP_W-1:0] acc_reg [EXP_LAT];
    logic [FB-1:0]    f_reg   [EXP_LAT];

    for (genvar k = 0; k < EXP_LAT; k++)
    begin : g_mul
        localparam logic [EXP_W-1:0] C = exp_const(k + 1);
        logic [EXP_W-1:0]   acc_in;
        logic [FB-1:0]      f_in;
        logic [2*EXP_W-1:0] prod;

        if (k == 0)
        begin : g_first
            assign acc_in = EXP_ONE;
            assign f_in   = frac;
        end
        else
        begin : g_next
            assign acc_in = acc_reg[k-1];
            assign f_in   = f_reg[k-1];
        end

        assign prod = acc_in * C;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                f_reg[k] <= f_in;
                if (f_in[FB-1-k])
                    acc_reg[k] <= prod[EXP_Q+EXP_W-1:EXP_Q];
                else
                    acc_reg[k] <= acc_in;
            end
        end
    end

    assign acc = acc_reg[EXP_LAT-1];

endmodule

`default_nettype wire

// ===== rtl/radial_falloff_pixel_generator_unit.sv =====
// Radial falloff pixel generator: one pixel coordinate in, one address and
// gradient value out, one per clock unless stalled. Depends on rfpg_pkg,
// rfpg_if and the rfpg_axis_div, rfpg_log2 and rfpg_exp2 units.
//
// Usage:
//   pixel  : valid/ready request channel carrying pixel_x, pixel_y.
//   result : valid/ready channel carrying byte_address and pixel_value.
//   cfg_*  : register write port; write only while no request is in flight.
// Throughput: one request per clock unless stalled. Every step is a register
//   stage: 16 divider stages per axis, 17 log2 stages, 16 exp2 multiplies,
//   plus input, square, base, exponent and four output stages (57 in all).
// Path: an accepted request passes every stage, then the output register.
// Stall: the pipeline moves as one; a result waiting on result.ready sits in
//   the output register and one more lands in a skid register, so requests
//   keep flowing until the skid fills. Nothing is dropped or repeated.
// Reset: rst_n (async, low) clears all valid bits and loads the registers
//   with 256x256 image, power 1.0, full peak, strides 4 and 1024, channel 0.
`timescale 1ns / 1ps
`default_nettype none

module radial_falloff_pixel_generator_unit import rfpg_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    rfpg_pixel_if.sink                 pixel,
    rfpg_result_if.source              result
);

    localparam int ADDR_LEN = ST_VAL;
    localparam int FLAG_LEN = ST_EXP - ST_BASE + 1;
    localparam int IP_LEN   = ST_EXP - ST_EXPO;
    localparam int AX_W     = COORD_W + PSTR_W;
    localparam int AY_W     = COORD_W + RSTR_W;
    localparam int SHIFT_W  = $clog2(EXP_Q + 1);
    localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(2);
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    // Configuration registers
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [POW_W-1:0]  power_reg;
    logic [PEAK_W-1:0] peak_reg;
    logic [PSTR_W-1:0] pstride_reg;
    logic [RSTR_W-1:0] rstride_reg;
    logic [CHAN_W-1:0] chan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= RST_WIDTH;
            height_reg  <= RST_HEIGHT;
            power_reg   <= RST_POWER;
            peak_reg    <= RST_PEAK;
            pstride_reg <= RST_PSTR;
            rstride_reg <= RST_RSTR;
            chan_reg    <= RST_CHAN;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg   <= DIM_W'(cfg_data);
                CFG_HEIGHT: height_reg  <= DIM_W'(cfg_data);
                CFG_POWER:  power_reg   <= POW_W'(cfg_data);
                CFG_PEAK:   peak_reg    <= cfg_data;
                CFG_PSTR:   pstride_reg <= PSTR_W'(cfg_data);
                CFG_RSTR:   rstride_reg <= cfg_data;
                CFG_CHAN:   chan_reg    <= CHAN_W'(cfg_data);
                default:    ;
            endcase
        end
    end

    // Pipeline control: whole pipe advances unless the skid is occupied
    logic                  pipe_en;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;

    assign pipe_en     = !skid_valid_reg;
    assign pixel.ready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (pipe_en)
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], pixel.valid};
    end

    // Input stage: clamp dims, axis distance from center, address products
    logic [DIM_W-1:0] dim_x, dim_y;
    logic [DEN_W-1:0] den_x, den_y;
    logic [NUM_W-1:0] two_x, two_y, num_x, num_y;

    assign dim_x = (width_reg < DIM_MIN) ? DIM_MIN :
                   (width_reg > DIM_MAX) ? DIM_MAX : width_reg;
    assign dim_y = (height_reg < DIM_MIN) ? DIM_MIN :
                   (height_reg > DIM_MAX) ? DIM_MAX : height_reg;
    assign den_x = DEN_W'(dim_x - 1'b1);
    assign den_y = DEN_W'(dim_y - 1'b1);
    assign two_x = {pixel.pixel_x, 1'b0};
    assign two_y = {pixel.pixel_y, 1'b0};
    assign num_x = (two_x >= NUM_W'(den_x)) ? two_x - NUM_W'(den_x) : NUM_W'(den_x) - two_x;
    assign num_y = (two_y >= NUM_W'(den_y)) ? two_y - NUM_W'(den_y) : NUM_W'(den_y) - two_y;

    logic [DEN_W-1:0] num_x_reg, num_y_reg, den_x_reg, den_y_reg;
    logic             sat_x_reg, sat_y_reg;
    logic [AX_W-1:0]  ax_reg;
    logic [AY_W-1:0]  ay_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            num_x_reg <= DEN_W'(num_x);
            num_y_reg <= DEN_W'(num_y);
            den_x_reg <= den_x;
            den_y_reg <= den_y;
            sat_x_reg <= num_x >= NUM_W'(den_x);
            sat_y_reg <= num_y >= NUM_W'(den_y);
            ax_reg    <= pixel.pixel_x * pstride_reg;
            ay_reg    <= pixel.pixel_y * rstride_reg;
        end
    end

    // Address delay line, wraps modulo 2^ADDR_W
    logic [ADDR_W-1:0] addr_reg [ADDR_LEN];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            addr_reg[0] <= ADDR_W'(ay_reg) + ADDR_W'(ax_reg) + ADDR_W'(chan_reg);
            for (int k = 1; k < ADDR_LEN; k++)
                addr_reg[k] <= addr_reg[k-1];
        end
    end

    // Axis magnitudes
    logic [MAG_W-1:0] mag_x, mag_y;

    rfpg_axis_div u_div_x (
        .clk (clk),
        .en  (pipe_en),
        .num (num_x_reg),
        .den (den_x_reg),
        .sat (sat_x_reg),
        .mag (mag_x)
    );

    rfpg_axis_div u_div_y (
        .clk (clk),
        .en  (pipe_en),
        .num (num_y_reg),
        .den (den_y_reg),
        .sat (sat_y_reg),
        .mag (mag_y)
    );

    // Squares
    logic [2*MAG_W-1:0] sq_x, sq_y;
    logic [MAG_W-1:0]   x2_reg, y2_reg;

    assign sq_x = mag_x * mag_x;
    assign sq_y = mag_y * mag_y;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            x2_reg <= sq_x[FB+MAG_W-1:FB];
            y2_reg <= sq_y[FB+MAG_W-1:FB];
        end
    end

    // Base 1 - r^2 clamped, with special cases flagged
    logic [MAG_W:0]   r2;
    logic [MAG_W-1:0] base_next;
    logic [MAG_W-1:0] base_reg;
    rfpg_flag_t       flag_next;
    rfpg_flag_t       flag_reg [FLAG_LEN];

    assign r2        = {1'b0, x2_reg} + {1'b0, y2_reg};
    assign base_next = (r2 >= {1'b0, ONE}) ? '0 : MAG_W'({1'b0, ONE} - r2);

    always_comb
    begin
        flag_next.spec     = (power_reg == '0) || (base_next == '0) || (base_next == ONE);
        flag_next.spec_one = (power_reg == '0) || (base_next == ONE);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            base_reg    <= base_next;
            flag_reg[0] <= flag_next;
            for (int k = 1; k < FLAG_LEN; k++)
                flag_reg[k] <= flag_reg[k-1];
        end
    end

    // log2 of base
    logic [FB-1:0]     log_frac;
    logic [LOGM_W-1:0] log_msb;

    rfpg_log2 u_log2 (
        .clk  (clk),
        .en   (pipe_en),
        .base (base_reg[FB-1:0]),
        .frac (log_frac),
        .msb  (log_msb)
    );

    // Exponent: power/2 times the negative log
    logic [NL_W-1:0]       nl;
    logic [POW_W+NL_W-1:0] e_prod;
    logic [E_W-1:0]        e_reg;

    assign nl     = ((NL_W'(FB) - NL_W'(log_msb)) << FB) - NL_W'(log_frac);
    assign e_prod = power_reg * nl;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            e_reg <= e_prod[POW_W+NL_W-1:POW_SHIFT];
    end

    // Integer part of the exponent rides beside the exp2 unit
    logic [E_W-FB-1:0] ip_full;
    logic [SHIFT_W-1:0] ip_reg   [IP_LEN];
    logic               ipz_reg  [IP_LEN];

    assign ip_full = e_reg[E_W-1:FB];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            ip_reg[0]  <= SHIFT_W'(ip_full);
            ipz_reg[0] <= ip_full > (E_W-FB)'(EXP_Q);
            for (int k = 1; k < IP_LEN; k++)
            begin
                ip_reg[k]  <= ip_reg[k-1];
                ipz_reg[k] <= ipz_reg[k-1];
            end
        end
    end

    logic [EXP_W-1:0] exp_acc;

    rfpg_exp2 u_exp2 (
        .clk  (clk),
        .en   (pipe_en),
        .frac (e_reg[FB-1:0]),
        .acc  (exp_acc)
    );

    // Alpha: special cases or the shifted exp2 result
    rfpg_flag_t       flag_last;
    logic [EXP_W-1:0] exp_shifted;
    logic [MAG_W-1:0] alpha_next, alpha_reg;

    assign flag_last   = flag_reg[FLAG_LEN-1];
    assign exp_shifted = (exp_acc >> ip_reg[IP_LEN-1]) >> (EXP_Q - FB);

    always_comb
    begin
        if (flag_last.spec)
            alpha_next = flag_last.spec_one ? ONE : '0;
        else if (ipz_reg[IP_LEN-1])
            alpha_next = '0;
        else
            alpha_next = MAG_W'(exp_shifted);
    end

    // Peak scaling, 255.996 scale, then divide by 1000 via reciprocal
    logic [PEAK_W-1:0]          peak_c;
    logic [P1_W-1:0]            p1_reg;
    logic [P1_W+SCALE_W-1:0]    scale_prod;
    logic [P2_W-1:0]            p2_reg;
    logic [P2_W+RECIP_W-1:0]    recip_prod;
    logic [P2_W+RECIP_W-RECIP_SHIFT-1:0] quot;
    logic [VAL_W-1:0]           val_reg;

    assign peak_c     = (peak_reg > PEAK_W'(ONE)) ? PEAK_W'(ONE) : peak_reg;
    assign scale_prod = p1_reg * VALUE_SCALE;
    assign recip_prod = p2_reg * RECIP_1000;
    assign quot       = recip_prod[P2_W+RECIP_W-1:RECIP_SHIFT];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            alpha_reg <= alpha_next;
            p1_reg    <= alpha_reg * peak_c;
            p2_reg    <= scale_prod[SCALE_SHIFT+P2_W-1:SCALE_SHIFT];
            val_reg   <= (quot > $bits(quot)'(VAL_MAX)) ? VAL_W'(VAL_MAX) : VAL_W'(quot);
        end
    end

    // Output register with skid
    logic [ADDR_W-1:0] out_addr_reg, skid_addr_reg;
    logic [VAL_W-1:0]  out_val_reg, skid_val_reg;
    logic              last_valid;

    assign last_valid = valid_reg[ST_VAL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= last_valid;
            end
        end
        else if (last_valid && pipe_en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result.ready)
        begin
            out_addr_reg <= skid_valid_reg ? skid_addr_reg : addr_reg[ADDR_LEN-1];
            out_val_reg  <= skid_valid_reg ? skid_val_reg : val_reg;
        end
        if (out_valid_reg && !result.ready && !skid_valid_reg)
        begin
            skid_addr_reg <= addr_reg[ADDR_LEN-1];
            skid_val_reg  <= val_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.byte_address = out_addr_reg;
    assign result.pixel_value  = out_val_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready && last_valid && !skid_valid_reg) |=> skid_valid_reg)
        else $error("result leaving the pipe was not caught by the skid");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(valid_reg))
        else $error("pipeline valid line moved during a stall");
`endif

endmodule

`default_nettype wire
